// File: hdl/vtp_pkg.sv
// Shared types and constants for the vertex transform and projection block.
`timescale 1ns / 1ps
package vtp_pkg;

  typedef struct packed {
    logic [1:0]         vertex_slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } vtp_in_t;

  typedef struct packed {
    logic [1:0]         slot_out;
    logic signed [23:0] cam_x;
    logic signed [23:0] cam_y;
    logic signed [23:0] cam_z;
    logic               visible;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
  } vtp_out_t;

  // Camera-space vertex handed from the transform front to the projection back.
  typedef struct packed {
    logic [1:0]         slot;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] cz;
    logic               vis;
  } vtp_cam_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_CLIP   = 3'd6;

  localparam logic signed [23:0] CAM_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CAM_MIN = -24'sh800000;

  // Divider operand widths: |cam| * scale < 2^39, divisor < 2^23.
  localparam int NUM_W = 40;
  localparam int DEN_W = 23;

endpackage

// File: hdl/vtp_front.sv
// Transform front: one multiply-add per cycle over the nine matrix terms.
`timescale 1ns / 1ps
module vtp_front #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vtp_pkg::vtp_in_t     in_data,
  input  logic [63:0]          row_x,
  input  logic [63:0]          row_y,
  input  logic [63:0]          row_z,
  input  logic [22:0]          near_clip,
  output logic                 q_valid,
  input  logic                 q_full,
  output vtp_pkg::vtp_cam_t    q_data
);
  import vtp_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MAC, F_DONE} fstate_t;

  fstate_t            state_r;
  vtp_in_t            item_r;
  logic [1:0]         row_r, col_r;
  logic signed [35:0] acc_r;
  logic signed [23:0] cx_r, cy_r;
  vtp_cam_t           res_r;

  logic [63:0]        row_sel;
  logic signed [15:0] coef, pos, trans;
  logic signed [31:0] prod;
  logic signed [35:0] acc_sum;
  logic signed [36:0] rnd;
  logic signed [23:0] cam;
  logic [22:0]        clip;

  assign in_stall = (state_r != F_IDLE);
  assign q_valid  = (state_r == F_DONE);
  assign q_data   = res_r;

  always_comb begin
    case (row_r)
      2'd0:    row_sel = row_x;
      2'd1:    row_sel = row_y;
      default: row_sel = row_z;
    endcase
    case (col_r)
      2'd0:    begin coef = row_sel[15:0];  pos = item_r.pos_x; end
      2'd1:    begin coef = row_sel[31:16]; pos = item_r.pos_y; end
      default: begin coef = row_sel[47:32]; pos = item_r.pos_z; end
    endcase
    trans   = row_sel[63:48];
    prod    = pos * coef;
    acc_sum = acc_r + 36'(prod);
    // Round to nearest, ties up, then add the translation.
    rnd = 37'(acc_sum + (36'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    rnd = rnd + 37'(trans);
    if (rnd > 37'(CAM_MAX))      cam = CAM_MAX;
    else if (rnd < 37'(CAM_MIN)) cam = CAM_MIN;
    else                         cam = rnd[23:0];
    clip = (near_clip == '0) ? 23'd1 : near_clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: if (in_valid) begin
          item_r  <= in_data;
          row_r   <= 2'd0;
          col_r   <= 2'd0;
          acc_r   <= '0;
          state_r <= F_MAC;
        end
        F_MAC: begin
          if (col_r == 2'd2) begin
            col_r <= 2'd0;
            acc_r <= '0;
            row_r <= row_r + 2'd1;
            case (row_r)
              2'd0: cx_r <= cam;
              2'd1: cy_r <= cam;
              default: begin
                res_r.slot <= item_r.vertex_slot;
                res_r.cx   <= cx_r;
                res_r.cy   <= cy_r;
                res_r.cz   <= cam;
                res_r.vis  <= (cam >= $signed({1'b0, clip}));
                state_r    <= F_DONE;
              end
            endcase
          end else begin
            col_r <= col_r + 2'd1;
            acc_r <= acc_sum;
          end
        end
        F_DONE: if (!q_full) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/vtp_queue.sv
// Two-entry queue between transform front and projection back.
`timescale 1ns / 1ps
module vtp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  vtp_pkg::vtp_cam_t wr_data,
  output logic              full,
  output logic              rd_valid,
  input  logic              rd_en,
  output vtp_pkg::vtp_cam_t rd_data
);
  import vtp_pkg::*;

  vtp_cam_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_en && !full) wp_r <= ~wp_r;
      if (rd_en && rd_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en && !full) - 2'(rd_en && rd_valid);
    end
  end

endmodule

// File: hdl/vtp_back.sv
// Projection back: multiply by scale, restoring divide, origin add, slot store.
`timescale 1ns / 1ps
module vtp_back #(
  parameter int VERTEX_SLOTS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_rd,
  input  vtp_pkg::vtp_cam_t  q_data,
  input  logic [15:0]        depth_scale,
  input  logic [15:0]        origin_x,
  input  logic [15:0]        origin_y,
  output logic               out_valid,
  input  logic               out_stall,
  output vtp_pkg::vtp_out_t  out_data
);
  import vtp_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_DIV, B_FIX, B_OUT} bstate_t;

  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int SLOT_W = $clog2(VERTEX_SLOTS > 1 ? VERTEX_SLOTS : 2);

  bstate_t            state_r;
  vtp_cam_t           cur_r;
  logic               axis_r;          // 0: x, 1: y
  logic [NUM_W-1:0]   num_r;
  logic               neg_r;
  logic [DEN_W:0]     rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [15:0] sx_r;
  logic [31:0]        store_r [VERTEX_SLOTS];
  vtp_out_t           out_r;

  logic signed [23:0] cval;
  logic signed [40:0] prod;
  logic [DEN_W:0]     rem_sh, rem_sub;
  logic signed [41:0] qsum;
  logic signed [15:0] qsat, org;
  logic               in_range;
  logic [SLOT_W-1:0]  slot_idx;
  logic [31:0]        stored;

  assign out_valid = (state_r == B_OUT);
  assign out_data  = out_r;
  assign q_rd      = (state_r == B_IDLE) && q_valid;

  always_comb begin
    cval    = axis_r ? cur_r.cy : cur_r.cx;
    prod    = cval * $signed({1'b0, depth_scale});
    rem_sh  = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, cur_r.cz[DEN_W-1:0]};
    org     = axis_r ? origin_y : origin_x;
    qsum    = (neg_r ? -$signed({2'b0, num_r}) : $signed({2'b0, num_r})) + 42'(org);
    if (qsum > 42'sd32767)       qsat = 16'sh7FFF;
    else if (qsum < -42'sd32768) qsat = -16'sh8000;
    else                         qsat = qsum[15:0];
    in_range = (32'(cur_r.slot) < 32'(VERTEX_SLOTS));
    slot_idx = SLOT_W'(cur_r.slot);
    stored   = in_range ? store_r[slot_idx] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      for (int i = 0; i < VERTEX_SLOTS; i++) store_r[i] <= '0;
    end else begin
      case (state_r)
        B_IDLE: if (q_valid) begin
          cur_r   <= q_data;
          axis_r  <= 1'b0;
          state_r <= q_data.vis ? B_MUL : B_FIX;
        end
        B_MUL: begin
          neg_r   <= prod[40];
          num_r   <= prod[40] ? NUM_W'(-prod) : NUM_W'(prod);
          rem_r   <= '0;
          cnt_r   <= CNT_W'(NUM_W);
          state_r <= B_DIV;
        end
        B_DIV: begin
          // One quotient bit per cycle; quotient shifts into num_r.
          if (!rem_sub[DEN_W]) begin
            rem_r <= rem_sub;
            num_r <= {num_r[NUM_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            num_r <= {num_r[NUM_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) state_r <= B_FIX;
        end
        B_FIX: begin
          out_r.slot_out <= cur_r.slot;
          out_r.cam_x    <= cur_r.cx;
          out_r.cam_y    <= cur_r.cy;
          out_r.cam_z    <= cur_r.cz;
          out_r.visible  <= cur_r.vis;
          if (!cur_r.vis) begin
            out_r.screen_x <= stored[15:0];
            out_r.screen_y <= stored[31:16];
            state_r        <= B_OUT;
          end else if (!axis_r) begin
            sx_r    <= qsat;
            axis_r  <= 1'b1;
            state_r <= B_MUL;
          end else begin
            out_r.screen_x <= sx_r;
            out_r.screen_y <= qsat;
            if (in_range)
              store_r[slot_idx] <= {qsat, sx_r};
            state_r <= B_OUT;
          end
        end
        B_OUT: if (!out_stall) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/vertex_transform_perspective_project_top.sv
// Top level of the vertex transform and perspective projection block.
// Path: transform front, two-entry queue, projection back (two 40-bit divides), output register.
// Pacing: for visible vertices the bit-serial divider that the x and y quotients share sets
//   the pace; hidden vertices skip the divider in the back, so the transform front sets
//   their pace.
// Reset: synchronous, active low; registers take their default values, screen store
//   clears to zero, queue empties.
`timescale 1ns / 1ps
module vertex_transform_perspective_project_top #(
  parameter int VERTEX_SLOTS   = 3,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  vtp_pkg::vtp_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output vtp_pkg::vtp_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vtp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import vtp_pkg::*;

  // Configuration registers.
  logic [63:0] row_x_r, row_y_r, row_z_r;
  logic [15:0] depth_scale_r, origin_x_r, origin_y_r;
  logic [22:0] near_clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r       <= 64'd1 << COEF_FRAC_BITS;
      row_y_r       <= (64'd1 << COEF_FRAC_BITS) << 16;
      row_z_r       <= (64'd1 << COEF_FRAC_BITS) << 32;
      depth_scale_r <= 16'd256;
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      near_clip_r   <= 23'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_X:       row_x_r       <= cfg_data;
        REG_ROW_Y:       row_y_r       <= cfg_data;
        REG_ROW_Z:       row_z_r       <= cfg_data;
        REG_DEPTH_SCALE: depth_scale_r <= cfg_data[15:0];
        REG_ORIGIN_X:    origin_x_r    <= cfg_data[15:0];
        REG_ORIGIN_Y:    origin_y_r    <= cfg_data[15:0];
        REG_NEAR_CLIP:   near_clip_r   <= cfg_data[22:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Front: transform and clip test.
  logic     fq_valid, fq_full, bq_valid, bq_rd;
  vtp_cam_t fq_data, bq_data;

  vtp_front #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .row_x(row_x_r), .row_y(row_y_r), .row_z(row_z_r), .near_clip(near_clip_r),
    .q_valid(fq_valid), .q_full(fq_full), .q_data(fq_data)
  );

  // Queue: lets the front start the next vertex while the divider works.
  vtp_queue u_queue (
    .clk, .rst_n, .wr_en(fq_valid), .wr_data(fq_data), .full(fq_full),
    .rd_valid(bq_valid), .rd_en(bq_rd), .rd_data(bq_data)
  );

  // Back: projection and screen store.
  vtp_back #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_back (
    .clk, .rst_n, .q_valid(bq_valid), .q_rd(bq_rd), .q_data(bq_data),
    .depth_scale(depth_scale_r), .origin_x(origin_x_r), .origin_y(origin_y_r),
    .out_valid, .out_stall, .out_data
  );

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");

  // Never overflow the queue: the front waits while it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fq_full |=> !(u_queue.cnt_r == 2'd3))
    else $error("queue overflow");

  // A visible result always has a positive camera z.
  a_vis_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.visible |-> out_data.cam_z > 0)
    else $error("visible vertex with non-positive z");

endmodule
